/* hdl/mccd_pkg.sv */
// Shared types, constants and codes for the minimum coin change block.
package mccd_pkg;

  localparam int MAX_REQUEST = 4095;
  localparam int MAX_DENOMS  = 6;
  localparam int ADDR_W      = $clog2(MAX_REQUEST + 1);
  localparam int DEPTH       = MAX_REQUEST + 1;
  localparam int CNT_W       = 12;
  localparam int DENOM_W     = 12;
  localparam int REQ_W       = 13;
  localparam int ACC_W       = CNT_W + 1;
  localparam int KIDX_W      = 3;
  localparam int PADDR_W     = 5;
  localparam int PDATA_W     = 32;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;
  localparam logic [ACC_W-1:0] ACC_INIT  = '1;

  localparam logic [2:0] REG_COUNT       = 3'd0;
  localparam logic [2:0] REG_DENOM_FIRST = 3'd1;
  localparam logic [2:0] REG_DENOM_LAST  = 3'd6;

  typedef logic [ADDR_W-1:0]  amt_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [DENOM_W-1:0] denom_t;
  typedef logic [KIDX_W-1:0]  kidx_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NEGATIVE  = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_NO_UNIT   = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]                 count;
    denom_t [MAX_DENOMS-1:0]    denom;
  } cfg_t;

endpackage

/* hdl/mccd_req_if.sv */
// Request channel interface: one signed amount per request.
interface mccd_req_if import mccd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [REQ_W-1:0] request;

  modport source (output valid, output request, input ready);
  modport sink   (input valid, input request, output ready);
endinterface

/* hdl/mccd_rsp_if.sv */
// Result channel interface: stamp count and status per request.
interface mccd_rsp_if import mccd_pkg::*; ();
  logic       valid;
  logic       ready;
  cnt_t       stamp_cnt;
  logic [1:0] status;

  modport source (output valid, output stamp_cnt, output status, input ready);
  modport sink   (input valid, input stamp_cnt, input status, output ready);
endinterface

/* hdl/mccd_table_ram.sv */
// Simple dual-port synchronous RAM with registered read data.
module mccd_table_ram #(
  parameter int Depth = 4096,
  parameter int Width = 12
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* hdl/mccd_engine.sv */
// Table sequencer: fills the best-count table one read per cycle and returns the result.
module mccd_engine import mccd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  mccd_req_if.sink    req_i,
  mccd_rsp_if.source  rsp_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_INIT   = 5'b00010,
    S_ISSUE  = 5'b00100,
    S_LAST   = 5'b01000,
    S_FINISH = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  amt_t             a_q, a_d;
  amt_t             amount_q, amount_d;
  kidx_t            k_q, k_d;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic             rd_use_q, rd_use_d;
  cnt_t             res_cnt_q, res_cnt_d;
  status_e          res_st_q, res_st_d;
  logic             out_valid_q, out_valid_d;
  cnt_t             out_cnt_q, out_cnt_d;
  status_e          out_st_q, out_st_d;

  logic             we;
  amt_t             waddr;
  cnt_t             wdata;
  amt_t             raddr;
  cnt_t             rdata;

  logic [2:0]       n_en;
  logic             has_unit;
  denom_t           d_cur;
  logic             usable;
  logic [ACC_W-1:0] cand;
  logic [ACC_W-1:0] best;
  cnt_t             best_sat;

  mccd_table_ram #(
    .Depth (DEPTH),
    .Width (CNT_W)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    n_en = (cfg_i.count > 3'(MAX_DENOMS)) ? 3'(MAX_DENOMS) : cfg_i.count;
    has_unit = 1'b0;
    for (int k = 0; k < MAX_DENOMS; k++) begin
      if ((3'(k) < n_en) && (cfg_i.denom[k] == denom_t'(1))) begin
        has_unit = 1'b1;
      end
    end
    d_cur    = cfg_i.denom[k_q];
    usable   = (d_cur != '0) && (d_cur <= a_q);
    raddr    = a_q - amt_t'(d_cur);
    cand     = rd_use_q ? ({1'b0, rdata} + ACC_W'(1)) : ACC_INIT;
    best     = (cand < acc_q) ? cand : acc_q;
    best_sat = (best > {1'b0, COUNT_MAX}) ? COUNT_MAX : best[CNT_W-1:0];
  end

  always_comb begin
    state_d     = state_q;
    a_d         = a_q;
    amount_d    = amount_q;
    k_d         = k_q;
    acc_d       = acc_q;
    rd_use_d    = rd_use_q;
    res_cnt_d   = res_cnt_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_cnt_d   = out_cnt_q;
    out_st_d    = out_st_q;
    we          = 1'b0;
    waddr       = a_q;
    wdata       = best_sat;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          res_cnt_d = '0;
          amount_d  = req_i.request[ADDR_W-1:0];
          if (!has_unit) begin
            res_st_d = ST_NO_UNIT;
            state_d  = S_FINISH;
          end else if (req_i.request[REQ_W-1]) begin
            res_st_d = ST_NEGATIVE;
            state_d  = S_FINISH;
          end else if ($unsigned(req_i.request) > REQ_W'(MAX_REQUEST)) begin
            res_st_d = ST_TOO_LARGE;
            state_d  = S_FINISH;
          end else if (req_i.request == '0) begin
            res_st_d = ST_OK;
            state_d  = S_FINISH;
          end else begin
            res_st_d = ST_OK;
            state_d  = S_INIT;
          end
        end
      end
      S_INIT: begin
        we       = 1'b1;
        waddr    = '0;
        wdata    = '0;
        a_d      = amt_t'(1);
        k_d      = '0;
        acc_d    = ACC_INIT;
        rd_use_d = 1'b0;
        state_d  = S_ISSUE;
      end
      S_ISSUE: begin
        rd_use_d = usable;
        acc_d    = best;
        if (k_q == n_en - 3'd1) begin
          state_d = S_LAST;
        end else begin
          k_d = k_q + kidx_t'(1);
        end
      end
      S_LAST: begin
        we       = 1'b1;
        rd_use_d = 1'b0;
        acc_d    = ACC_INIT;
        k_d      = '0;
        if (a_q == amount_q) begin
          res_cnt_d = best_sat;
          res_st_d  = ST_OK;
          state_d   = S_FINISH;
        end else begin
          a_d     = a_q + amt_t'(1);
          state_d = S_ISSUE;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_cnt_d   = res_cnt_q;
          out_st_d    = res_st_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_use_q    <= 1'b0;
      out_valid_q <= 1'b0;
      k_q         <= '0;
      a_q         <= '0;
    end else begin
      state_q     <= state_d;
      rd_use_q    <= rd_use_d;
      out_valid_q <= out_valid_d;
      k_q         <= k_d;
      a_q         <= a_d;
    end
  end

  always_ff @(posedge clk_i) begin
    amount_q  <= amount_d;
    acc_q     <= acc_d;
    res_cnt_q <= res_cnt_d;
    res_st_q  <= res_st_d;
    out_cnt_q <= out_cnt_d;
    out_st_q  <= out_st_d;
  end

  assign req_i.ready     = (state_q == S_IDLE);
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.stamp_cnt = out_cnt_q;
  assign rsp_o.status    = out_st_q;

endmodule

/* hdl/min_coin_change_dp.sv */
// Top level: configuration registers behind an APB-style port and the table sequencer.
//
// Requests arrive on req_i (valid/ready) as a signed 13-bit amount; one result per
// request leaves on rsp_o (valid/ready) with the fewest stamps and a status code.
// Denominations and the enabled count are written through the APB-style port,
// register i at byte address 4*i; reads return the stored values.
// A request that is zero, negative, too large or meets a setup without a unit
// denomination is answered through S_FINISH without touching the table.
// Otherwise the block writes table entry 0 in S_INIT, then works through each
// amount from 1 up to the request, where n is the enabled count: S_ISSUE makes
// one table read per cycle for each of the n denominations, and S_LAST collects
// the last read and writes the entry back. The next request is taken only after
// the result has moved on from S_FINISH to the output register.
// The single read port of the table RAM is why the reads are issued one by one.
// The result sits in an output register, so the next request is taken while it
// waits; if the receiver still stalls when the next result is ready, the
// sequencer holds that result until the register is free.
// Reset sets the count and every denomination to 1 and empties the output.
module min_coin_change_dp import mccd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  mccd_req_if.sink           req_i,
  mccd_rsp_if.source         rsp_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [2:0]               count_q;
  denom_t [MAX_DENOMS-1:0]  denom_q;
  logic [2:0]               reg_idx;
  logic                     wr_en;
  cfg_t                     cfg;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 3'd1;
      for (int k = 0; k < MAX_DENOMS; k++) begin
        denom_q[k] <= denom_t'(1);
      end
    end else if (wr_en) begin
      if (reg_idx == REG_COUNT) begin
        count_q <= pwdata[2:0];
      end else if ((reg_idx >= REG_DENOM_FIRST) && (reg_idx <= REG_DENOM_LAST)) begin
        denom_q[reg_idx - REG_DENOM_FIRST] <= pwdata[DENOM_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_COUNT) begin
      prdata = PDATA_W'(count_q);
    end else if ((reg_idx >= REG_DENOM_FIRST) && (reg_idx <= REG_DENOM_LAST)) begin
      prdata = PDATA_W'(denom_q[reg_idx - REG_DENOM_FIRST]);
    end
  end

  assign cfg.count = count_q;
  assign cfg.denom = denom_q;

  mccd_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .req_i  (req_i),
    .rsp_o  (rsp_o)
  );

endmodule

/* sim/tb.sv */
// Self-checking testbench for the minimum stamp count block, with its own predictor.
`timescale 1ns / 100ps

module tb;
  import mccd_pkg::*;

  typedef logic signed [REQ_W-1:0] amount_t;

  localparam int REG_SPARE = REG_DENOM_LAST + 1;

  class stamp_count_board;
    logic [2:0]  count_reg;
    denom_t      denom_reg [MAX_DENOMS];
    cnt_t        awaited_stamps [$];
    status_e     awaited_status [$];
    int unsigned fewest_table [DEPTH];
    int          errors;
    int          requests_noted;
    int          results_checked;
    int          status_seen [4];

    function new();
      count_reg = 3'd1;
      foreach (denom_reg[k]) denom_reg[k] = denom_t'(1);
      errors = 0;
      requests_noted = 0;
      results_checked = 0;
      foreach (status_seen[k]) status_seen[k] = 0;
    endfunction

    function void write_reg(input int idx, input logic [PDATA_W-1:0] data);
      if (idx == REG_COUNT) begin
        count_reg = data[2:0];
      end else if (idx <= REG_DENOM_LAST) begin
        denom_reg[idx - REG_DENOM_FIRST] = data[DENOM_W-1:0];
      end
    endfunction

    function int pending();
      return awaited_stamps.size();
    endfunction

    function void note_request(input amount_t req);
      int unsigned n;
      int unsigned best;
      int unsigned c;
      int          amount;
      bit          unit;
      cnt_t        stamps;
      status_e     st;
      n = (count_reg > MAX_DENOMS) ? MAX_DENOMS : count_reg;
      unit = 1'b0;
      for (int k = 0; k < n; k++) begin
        if (denom_reg[k] == denom_t'(1)) unit = 1'b1;
      end
      stamps = '0;
      if (!unit) begin
        st = ST_NO_UNIT;
      end else if (req < 0) begin
        st = ST_NEGATIVE;
      end else if (int'(req) > MAX_REQUEST) begin
        st = ST_TOO_LARGE;
      end else begin
        st = ST_OK;
        amount = int'(req);
        fewest_table[0] = 0;
        for (int a = 1; a <= amount; a++) begin
          best = 32'hFFFF_FFFF;
          for (int k = 0; k < n; k++) begin
            if (denom_reg[k] != '0 && int'(denom_reg[k]) <= a) begin
              c = fewest_table[a - int'(denom_reg[k])] + 1;
              if (c < best) best = c;
            end
          end
          if (best > COUNT_MAX) best = COUNT_MAX;
          fewest_table[a] = best;
        end
        stamps = cnt_t'(fewest_table[amount]);
      end
      awaited_stamps.insert(awaited_stamps.size(), stamps);
      awaited_status.insert(awaited_status.size(), st);
      status_seen[st]++;
      requests_noted++;
    endfunction

    function void check_result(input cnt_t stamps, input logic [1:0] status);
      cnt_t    exp_stamps;
      status_e exp_status;
      results_checked++;
      if (awaited_stamps.size() == 0) begin
        errors++;
        $display("%0t: result with no request waiting, stamps %0d status %0d",
                 $time, stamps, status);
        return;
      end
      exp_stamps = awaited_stamps.pop_front();
      exp_status = awaited_status.pop_front();
      if (stamps !== exp_stamps) begin
        errors++;
        $display("%0t: stamp count expected %0d, got %0d", $time, exp_stamps, stamps);
      end
      if (status !== exp_status) begin
        errors++;
        $display("%0t: status expected %0d, got %0d", $time, exp_status, status);
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int send_idle_pct;
  int recv_idle_pct;
  int setups_loaded;

  stamp_count_board board = new();

  mccd_req_if req_ch ();
  mccd_rsp_if rsp_ch ();

  min_coin_change_dp dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_ch),
    .rsp_o   (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  task automatic apb_access(input logic write, input int idx, input logic [PDATA_W-1:0] data,
                            output logic [PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= PADDR_W'(idx * 4);
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_register(input int idx, input logic [PDATA_W-1:0] data);
    logic [PDATA_W-1:0] rdata;
    logic [PDATA_W-1:0] expected;
    apb_access(1'b1, idx, data, rdata);
    board.write_reg(idx, data);
    if (idx <= REG_DENOM_LAST) begin
      apb_access(1'b0, idx, '0, rdata);
      if (idx == REG_COUNT) expected = PDATA_W'(board.count_reg);
      else expected = PDATA_W'(board.denom_reg[idx - REG_DENOM_FIRST]);
      if (rdata !== expected) begin
        board.errors++;
        $display("%0t: register %0d read expected %0h, got %0h", $time, idx, expected, rdata);
      end
    end
  endtask

  task automatic load_setup(input logic [2:0] count, input denom_t vals [MAX_DENOMS]);
    logic [PDATA_W-1:0] data;
    data = $urandom;
    data[2:0] = count;
    set_register(REG_COUNT, data);
    for (int k = 0; k < MAX_DENOMS; k++) begin
      data = $urandom;
      data[DENOM_W-1:0] = vals[k];
      set_register(REG_DENOM_FIRST + k, data);
    end
    setups_loaded++;
  endtask

  function automatic denom_t random_denom();
    case ($urandom_range(9))
      0:       return '0;
      1, 2:    return denom_t'($urandom);
      default: return denom_t'($urandom_range(2, 40));
    endcase
  endfunction

  task automatic random_setup();
    denom_t     vals [MAX_DENOMS];
    logic [2:0] count;
    int         pick;
    int         enabled;
    pick = $urandom_range(19);
    if (pick == 0) count = 3'd0;
    else if (pick == 1) count = 3'd7;
    else count = 3'($urandom_range(1, MAX_DENOMS));
    foreach (vals[k]) vals[k] = random_denom();
    enabled = (count > MAX_DENOMS) ? MAX_DENOMS : count;
    if (enabled > 0 && $urandom_range(9) != 0) vals[$urandom_range(enabled - 1)] = denom_t'(1);
    load_setup(count, vals);
    if ($urandom_range(3) == 0) set_register(REG_SPARE, $urandom);
  endtask

  function automatic amount_t random_amount();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return amount_t'(-int'($urandom_range(1, 4096)));
    if (pick < 13) return amount_t'($urandom_range(2048, MAX_REQUEST));
    if (pick < 25) return amount_t'($urandom_range(0, 15));
    return amount_t'($urandom_range(0, 300));
  endfunction

  task automatic send_request(input amount_t amt);
    if ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid   <= 1'b0;
      req_ch.request <= amount_t'($urandom);
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    req_ch.valid   <= 1'b1;
    req_ch.request <= amt;
    do @(posedge clk_i); while (!req_ch.ready);
    board.note_request(amt);
  endtask

  task automatic finish_batch();
    req_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  task automatic random_phase(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (3) begin
      random_setup();
      repeat (9) send_request(random_amount());
      finish_batch();
    end
  endtask

  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if (rsp_ch.valid && rsp_ch.ready) board.check_result(rsp_ch.stamp_cnt, rsp_ch.status);
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    rst_ni         <= 1'b0;
    req_ch.valid   <= 1'b0;
    req_ch.request <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    send_idle_pct = 11;
    recv_idle_pct = 73;
    setups_loaded = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset setup: a single unit stamp, so the count equals the amount.
    send_request(amount_t'(0));
    send_request(amount_t'(1));
    send_request(amount_t'(MAX_REQUEST));
    send_request(amount_t'(-1));
    send_request(amount_t'(-4096));
    finish_batch();

    // Greedy choice fails here: six is two threes, not four plus two ones.
    load_setup(3'd3, '{12'd1, 12'd3, 12'd4, 12'd4095, 12'd0, 12'd2});
    send_request(amount_t'(6));
    send_request(amount_t'(7));
    send_request(amount_t'(12));
    send_request(amount_t'(2));
    finish_batch();

    // No denomination enabled; the setup fault outranks a negative request.
    load_setup(3'd0, '{12'd1, 12'd1, 12'd1, 12'd1, 12'd1, 12'd1});
    send_request(amount_t'(5));
    send_request(amount_t'(-3));
    finish_batch();

    // Count above six saturates; a zero stamp is skipped; the largest stamp is used.
    load_setup(3'd7, '{12'd4095, 12'd0, 12'd7, 12'd13, 12'd1, 12'd29});
    send_request(amount_t'(MAX_REQUEST));
    send_request(amount_t'(4094));
    send_request(amount_t'(100));
    finish_batch();

    // A zero stamp does not count as the unit stamp.
    load_setup(3'd6, '{12'd0, 12'd2, 12'd3, 12'd4, 12'd5, 12'd6});
    send_request(amount_t'(10));
    send_request(amount_t'(-7));
    finish_batch();

    // The unit stamp lies beyond the enabled count; a write to the spare address is ignored.
    load_setup(3'd2, '{12'd2, 12'd3, 12'd1, 12'd1, 12'd1, 12'd1});
    set_register(REG_SPARE, 32'hFFFF_FFFF);
    send_request(amount_t'(9));
    send_request(amount_t'(0));
    finish_batch();

    random_phase(11, 73);
    random_phase(73, 11);
    random_phase(0, 0);

    repeat (16) @(posedge clk_i);
    $display("Run covered %0d requests and %0d results over %0d register setups.",
             board.requests_noted, board.results_checked, setups_loaded);
    $display("Statuses: %0d ok, %0d negative, %0d too large, %0d without a unit stamp.",
             board.status_seen[ST_OK], board.status_seen[ST_NEGATIVE],
             board.status_seen[ST_TOO_LARGE], board.status_seen[ST_NO_UNIT]);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("Run timed out with %0d results outstanding.", board.pending());
    $display("Mismatches found");
    $finish;
  end

endmodule
